// File: design/srvc_pkg.sv
// Shared types and constants for the segment/rectangle visibility check unit.
// Holds the command codes, the queue item that passes from front to back and the
// back end's state type. It depends on nothing else.
package srvc_pkg;

	localparam int MAX_RECTS_DEF = 64;

	// Depth of the queue between front and back. It must be a power of two.
	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam int CMD_W     = 2;
	localparam int COORD_W   = 16;
	localparam int SIZE_W    = 15;
	localparam int OWNER_W   = 6;
	// Products need at most 36 bits, and their sums at most 37 bits.
	localparam int PROD_W    = 36;
	localparam int SUM_W     = 38;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	typedef enum logic [1:0] {
		KIND_CLEAR,
		KIND_LOAD,
		KIND_QUERY
	} kind_t;

	typedef struct packed {
		kind_t                      kind;
		logic                       same_owner;
		logic signed [COORD_W-1:0]  x1;
		logic signed [COORD_W-1:0]  y1;
		logic signed [COORD_W-1:0]  x2;
		logic signed [COORD_W-1:0]  y2;
		logic signed [COORD_W-1:0]  left;
		logic signed [COORD_W-1:0]  top;
		logic [SIZE_W-1:0]          width;
		logic [SIZE_W-1:0]          height;
	} item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0]  left;
		logic signed [COORD_W-1:0]  top;
		logic [SIZE_W-1:0]          width;
		logic [SIZE_W-1:0]          height;
	} rect_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_WALK,
		B_DRAIN,
		B_REPORT
	} back_state_t;

endpackage

// File: design/segment_rectangle_visibility_check_unit.sv
// Segment/rectangle visibility check. Clear and load words are applied when the back
// end takes them; a query walks all stored rectangles, as the table's single read port
// feeds the four-side crossing pipeline one rectangle a cycle. A shared-owner query
// skips the walk, and the back end takes no new word until a query's result has moved
// into the output register. Reset (arst_n, asynchronous, active low) empties both
// queues and the table count; the table contents are not cleared.
module segment_rectangle_visibility_check_unit #(
	parameter int MAX_RECTS = srvc_pkg::MAX_RECTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [srvc_pkg::CMD_W-1:0]          cmd,
	input  logic signed [srvc_pkg::COORD_W-1:0] start_x,
	input  logic signed [srvc_pkg::COORD_W-1:0] start_y,
	input  logic signed [srvc_pkg::COORD_W-1:0] end_x,
	input  logic signed [srvc_pkg::COORD_W-1:0] end_y,
	input  logic [srvc_pkg::OWNER_W-1:0]        start_owner,
	input  logic [srvc_pkg::OWNER_W-1:0]        end_owner,
	input  logic signed [srvc_pkg::COORD_W-1:0] rect_left,
	input  logic signed [srvc_pkg::COORD_W-1:0] rect_top,
	input  logic [srvc_pkg::SIZE_W-1:0]         rect_width,
	input  logic [srvc_pkg::SIZE_W-1:0]         rect_height,
	output logic                                empty,
	input  logic                                pop,
	output logic                                blocked
);
	import srvc_pkg::*;

	item_t item;
	logic  item_valid;
	logic  item_ready;
	logic  res_valid;
	logic  res_ready;
	logic  res_blocked;
	logic  out_valid_q;
	logic  blocked_q;

	srvc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.cmd         (cmd),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.start_owner (start_owner),
		.end_owner   (end_owner),
		.rect_left   (rect_left),
		.rect_top    (rect_top),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item)
	);

	srvc_back #(
		.MAX_RECTS (MAX_RECTS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_blocked (res_blocked)
	);

	// Output register: a new result may enter in the cycle the old one is popped.
	assign res_ready = !out_valid_q || pop;
	assign empty     = !out_valid_q;
	assign blocked   = blocked_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			blocked_q <= res_blocked;
		end
	end

endmodule

// File: design/srvc_front.sv
// Front end of the visibility check unit: takes input words, decodes the command
// and queues the classified item for the back end. Depends on srvc_pkg.
module srvc_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [srvc_pkg::CMD_W-1:0]        cmd,
	input  logic signed [srvc_pkg::COORD_W-1:0] start_x,
	input  logic signed [srvc_pkg::COORD_W-1:0] start_y,
	input  logic signed [srvc_pkg::COORD_W-1:0] end_x,
	input  logic signed [srvc_pkg::COORD_W-1:0] end_y,
	input  logic [srvc_pkg::OWNER_W-1:0]      start_owner,
	input  logic [srvc_pkg::OWNER_W-1:0]      end_owner,
	input  logic signed [srvc_pkg::COORD_W-1:0] rect_left,
	input  logic signed [srvc_pkg::COORD_W-1:0] rect_top,
	input  logic [srvc_pkg::SIZE_W-1:0]       rect_width,
	input  logic [srvc_pkg::SIZE_W-1:0]       rect_height,
	output logic                              item_valid,
	input  logic                              item_ready,
	output srvc_pkg::item_t                   item
);
	import srvc_pkg::*;

	item_t           fifo_mem [QDEPTH];
	logic [QAW-1:0]  wr_ptr_q;
	logic [QAW-1:0]  rd_ptr_q;
	logic [QCW-1:0]  cnt_q;
	item_t           new_item;
	logic            known_cmd;
	logic            enq;
	logic            deq;

	always_comb begin
		new_item.same_owner = (start_owner == end_owner);
		new_item.x1         = start_x;
		new_item.y1         = start_y;
		new_item.x2         = end_x;
		new_item.y2         = end_y;
		new_item.left       = rect_left;
		new_item.top        = rect_top;
		new_item.width      = rect_width;
		new_item.height     = rect_height;
		known_cmd           = 1'b1;
		unique case (cmd)
			CMD_CLEAR: new_item.kind = KIND_CLEAR;
			CMD_LOAD:  new_item.kind = KIND_LOAD;
			CMD_QUERY: new_item.kind = KIND_QUERY;
			default: begin
				// The spare command code is taken and dropped here.
				new_item.kind = KIND_CLEAR;
				known_cmd     = 1'b0;
			end
		endcase
	end

	assign full       = (cnt_q == QCW'(QDEPTH));
	assign enq        = push && !full && known_cmd;
	assign item_valid = (cnt_q != '0);
	assign deq        = item_valid && item_ready;
	assign item       = fifo_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			fifo_mem[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (deq && !enq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: design/srvc_back.sv
// Back end of the visibility check unit: rectangle table, the walk over it and the
// four-side crossing pipeline. Takes items from srvc_front; depends on srvc_pkg.
module srvc_back #(
	parameter int MAX_RECTS = srvc_pkg::MAX_RECTS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  srvc_pkg::item_t item,
	output logic            res_valid,
	input  logic            res_ready,
	output logic            res_blocked
);
	import srvc_pkg::*;

	localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
	localparam int CW = $clog2(MAX_RECTS + 1);

	back_state_t  state_q;
	back_state_t  state_d;
	logic         start_clear;
	logic         start_load;
	logic         start_query;
	logic         issue;

	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic          hit_q;

	logic signed [COORD_W-1:0] qx1_q;
	logic signed [COORD_W-1:0] qy1_q;
	logic signed [COORD_W:0]   qdx_q;
	logic signed [COORD_W:0]   qdy_q;

	rect_t rect_mem [MAX_RECTS];
	rect_t rd_s1;
	logic  v_s1;
	logic  v_s2;
	logic  v_s3;
	logic  v_s4;

	logic signed [COORD_W-1:0] w_s2;
	logic signed [COORD_W-1:0] h_s2;
	logic signed [COORD_W:0]   ymt_s2;
	logic signed [COORD_W+2:0] ymb_s2;
	logic signed [COORD_W:0]   xml_s2;
	logic signed [COORD_W+2:0] xmr_s2;

	logic signed [PROD_W-1:0] p_wdy_s3;
	logic signed [PROD_W-1:0] p_wymt_s3;
	logic signed [PROD_W-1:0] p_wymb_s3;
	logic signed [PROD_W-1:0] p_hdx_s3;
	logic signed [PROD_W-1:0] p_hxmr_s3;
	logic signed [PROD_W-1:0] p_hxml_s3;
	logic signed [PROD_W-1:0] p_dxymt_s3;
	logic signed [PROD_W-1:0] p_dxymb_s3;
	logic signed [PROD_W-1:0] p_dyxml_s3;
	logic signed [PROD_W-1:0] p_dyxmr_s3;

	// Index 0 top, 1 right, 2 bottom, 3 left.
	logic signed [SUM_W-1:0] dh_s4;
	logic signed [SUM_W-1:0] dv_s4;
	logic signed [SUM_W-1:0] na_s4 [4];
	logic signed [SUM_W-1:0] nb_s4 [4];
	logic                    hit_s4;

	function automatic logic ratio_open(input logic signed [SUM_W-1:0] num,
	                                    input logic signed [SUM_W-1:0] den);
		logic r;
		r = 1'b0;
		if (den > 0) begin
			r = (num > 0) && (num < den);
		end else if (den < 0) begin
			r = (num < 0) && (num > den);
		end
		return r;
	endfunction

	always_comb begin
		state_d     = state_q;
		item_ready  = 1'b0;
		start_clear = 1'b0;
		start_load  = 1'b0;
		start_query = 1'b0;
		issue       = 1'b0;
		res_valid   = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					unique case (item.kind)
						KIND_CLEAR: start_clear = 1'b1;
						KIND_LOAD:  start_load  = 1'b1;
						KIND_QUERY: begin
							start_query = 1'b1;
							state_d     = item.same_owner ? B_REPORT : B_WALK;
						end
						default: ;
					endcase
				end
			end
			B_WALK: begin
				if (idx_q < count_q) begin
					issue = 1'b1;
				end else begin
					state_d = B_DRAIN;
				end
			end
			B_DRAIN: begin
				if (!(v_s1 || v_s2 || v_s3 || v_s4)) begin
					state_d = B_REPORT;
				end
			end
			B_REPORT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	assign res_blocked = hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			hit_q   <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			if (start_clear) begin
				count_q <= '0;
			end else if (start_load && (count_q < CW'(MAX_RECTS))) begin
				count_q <= count_q + 1'b1;
			end
			if (start_query) begin
				idx_q <= '0;
				hit_q <= item.same_owner;
			end else begin
				if (issue) begin
					idx_q <= idx_q + 1'b1;
				end
				if (v_s4 && hit_s4) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	// Query segment, held for the whole walk.
	always_ff @(posedge clk) begin
		if (start_query) begin
			qx1_q <= item.x1;
			qy1_q <= item.y1;
			qdx_q <= $signed({item.x2[COORD_W-1], item.x2}) - $signed({item.x1[COORD_W-1], item.x1});
			qdy_q <= $signed({item.y2[COORD_W-1], item.y2}) - $signed({item.y1[COORD_W-1], item.y1});
		end
	end

	always_ff @(posedge clk) begin
		if (start_load && (count_q < CW'(MAX_RECTS))) begin
			rect_mem[count_q[AW-1:0]] <= '{left: item.left, top: item.top,
			                               width: item.width, height: item.height};
		end
	end

	always_ff @(posedge clk) begin
		rd_s1 <= rect_mem[idx_q[AW-1:0]];
	end

	// Offsets of the segment start from the rectangle's corners.
	always_ff @(posedge clk) begin
		w_s2   <= $signed({1'b0, rd_s1.width});
		h_s2   <= $signed({1'b0, rd_s1.height});
		ymt_s2 <= (COORD_W+1)'(qy1_q) - (COORD_W+1)'(rd_s1.top);
		ymb_s2 <= (COORD_W+3)'(qy1_q) - (COORD_W+3)'(rd_s1.top)
		          + (COORD_W+3)'($signed({1'b0, rd_s1.height}));
		xml_s2 <= (COORD_W+1)'(qx1_q) - (COORD_W+1)'(rd_s1.left);
		xmr_s2 <= (COORD_W+3)'(qx1_q) - (COORD_W+3)'(rd_s1.left)
		          - (COORD_W+3)'($signed({1'b0, rd_s1.width}));
	end

	always_ff @(posedge clk) begin
		p_wdy_s3   <= PROD_W'(w_s2)  * PROD_W'(qdy_q);
		p_wymt_s3  <= PROD_W'(w_s2)  * PROD_W'(ymt_s2);
		p_wymb_s3  <= PROD_W'(w_s2)  * PROD_W'(ymb_s2);
		p_hdx_s3   <= PROD_W'(h_s2)  * PROD_W'(qdx_q);
		p_hxmr_s3  <= PROD_W'(h_s2)  * PROD_W'(xmr_s2);
		p_hxml_s3  <= PROD_W'(h_s2)  * PROD_W'(xml_s2);
		p_dxymt_s3 <= PROD_W'(qdx_q) * PROD_W'(ymt_s2);
		p_dxymb_s3 <= PROD_W'(qdx_q) * PROD_W'(ymb_s2);
		p_dyxml_s3 <= PROD_W'(qdy_q) * PROD_W'(xml_s2);
		p_dyxmr_s3 <= PROD_W'(qdy_q) * PROD_W'(xmr_s2);
	end

	// Horizontal sides share one denominator, and so do the vertical sides.
	always_ff @(posedge clk) begin
		dh_s4    <= -SUM_W'(p_wdy_s3);
		dv_s4    <= -SUM_W'(p_hdx_s3);
		na_s4[0] <= SUM_W'(p_wymt_s3);
		na_s4[1] <= SUM_W'(p_hxmr_s3);
		na_s4[2] <= SUM_W'(p_wymb_s3);
		na_s4[3] <= SUM_W'(p_hxml_s3);
		nb_s4[0] <= SUM_W'(p_dxymt_s3) - SUM_W'(p_dyxml_s3);
		nb_s4[1] <= SUM_W'(p_dxymt_s3) - SUM_W'(p_dyxmr_s3);
		nb_s4[2] <= SUM_W'(p_dxymb_s3) - SUM_W'(p_dyxml_s3);
		nb_s4[3] <= SUM_W'(p_dxymt_s3) - SUM_W'(p_dyxml_s3);
	end

	assign hit_s4 = (ratio_open(na_s4[0], dh_s4) && ratio_open(nb_s4[0], dh_s4))
	             || (ratio_open(na_s4[1], dv_s4) && ratio_open(nb_s4[1], dv_s4))
	             || (ratio_open(na_s4[2], dh_s4) && ratio_open(nb_s4[2], dh_s4))
	             || (ratio_open(na_s4[3], dv_s4) && ratio_open(nb_s4[3], dv_s4));

endmodule

// File: test/tb_top.sv
// Self-checking testbench for segment_rectangle_visibility_check_unit.
// Drives clear, load and query words through the push/full queue, predicts each query answer
// from a shadow copy of the rectangle table and checks it on the empty/pop side. Needs srvc_pkg.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import srvc_pkg::*;

	localparam int TABLE_DEPTH = MAX_RECTS_DEF;
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

	typedef struct {
		logic [CMD_W-1:0]          cmd;
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic [OWNER_W-1:0]        start_owner;
		logic [OWNER_W-1:0]        end_owner;
		logic signed [COORD_W-1:0] rect_left;
		logic signed [COORD_W-1:0] rect_top;
		logic [SIZE_W-1:0]         rect_width;
		logic [SIZE_W-1:0]         rect_height;
	} cmd_word_t;

	logic                      clk;
	logic                      arst_n      = 1'b0;
	logic                      push        = 1'b0;
	logic                      full;
	logic [CMD_W-1:0]          cmd         = CMD_CLEAR;
	logic signed [COORD_W-1:0] start_x     = '0;
	logic signed [COORD_W-1:0] start_y     = '0;
	logic signed [COORD_W-1:0] end_x       = '0;
	logic signed [COORD_W-1:0] end_y       = '0;
	logic [OWNER_W-1:0]        start_owner = '0;
	logic [OWNER_W-1:0]        end_owner   = '0;
	logic signed [COORD_W-1:0] rect_left   = '0;
	logic signed [COORD_W-1:0] rect_top    = '0;
	logic [SIZE_W-1:0]         rect_width  = '0;
	logic [SIZE_W-1:0]         rect_height = '0;
	logic                      empty;
	logic                      pop         = 1'b0;
	logic                      blocked;

	rect_t shadow_rects [TABLE_DEPTH];
	int    shadow_count = 0;
	bit    blocked_expected [$];

	int mismatch_count    = 0;
	int results_seen      = 0;
	bit send_idle_on      = 1'b1;
	bit pop_idle_on       = 1'b1;
	int pop_hold_request  = 0;

	segment_rectangle_visibility_check_unit i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("segment_rectangle_visibility_check_unit regression: fail");
		$finish;
	end

	task automatic report_mismatch(input string what);
		if (mismatch_count < 100) begin
			$display("%0t ns mismatch: %s", $time, what);
		end
		mismatch_count++;
	endtask

	// Answer must lie strictly between zero and the denominator, either sign.
	function automatic bit ratio_in_open_unit(input longint num, input longint den);
		if (den > 0) return num > 0 && num < den;
		if (den < 0) return num < 0 && num > den;
		return 1'b0;
	endfunction

	function automatic bit segment_crosses_side(input longint x1, y1, x2, y2, x3, y3, x4, y4);
		longint d;
		longint na;
		longint nb;
		d  = (y4 - y3) * (x2 - x1) - (x4 - x3) * (y2 - y1);
		na = (x4 - x3) * (y1 - y3) - (y4 - y3) * (x1 - x3);
		nb = (x2 - x1) * (y1 - y3) - (y2 - y1) * (x1 - x3);
		return ratio_in_open_unit(na, d) && ratio_in_open_unit(nb, d);
	endfunction

	function automatic bit predict_blocked(input cmd_word_t w);
		longint x1, y1, x2, y2;
		longint l, t, r, b, wd, ht;
		x1 = w.start_x;
		y1 = w.start_y;
		x2 = w.end_x;
		y2 = w.end_y;
		if (w.start_owner == w.end_owner) return 1'b1;
		for (int i = 0; i < shadow_count; i++) begin
			l  = shadow_rects[i].left;
			t  = shadow_rects[i].top;
			wd = shadow_rects[i].width;
			ht = shadow_rects[i].height;
			r  = l + wd;
			b  = t - ht;
			if (segment_crosses_side(x1, y1, x2, y2, l, t, r, t) ||
			    segment_crosses_side(x1, y1, x2, y2, r, t, r, b) ||
			    segment_crosses_side(x1, y1, x2, y2, l, b, r, b) ||
			    segment_crosses_side(x1, y1, x2, y2, l, t, l, b)) return 1'b1;
		end
		return 1'b0;
	endfunction

	// Applies an accepted word to the shadow table; a query queues its answer.
	function automatic void record_word(input cmd_word_t w);
		case (w.cmd)
			CMD_CLEAR: begin
				shadow_count = 0;
			end
			CMD_LOAD: begin
				if (shadow_count < TABLE_DEPTH) begin
					shadow_rects[shadow_count] = '{w.rect_left, w.rect_top,
						w.rect_width, w.rect_height};
					shadow_count++;
				end
			end
			CMD_QUERY: begin
				blocked_expected.push_back(predict_blocked(w));
			end
			default: begin
			end
		endcase
	endfunction

	// Fields a command does not use carry random values throughout.
	function automatic cmd_word_t spare_word();
		cmd_word_t w;
		w.cmd         = CMD_SPARE;
		w.start_x     = COORD_W'($urandom());
		w.start_y     = COORD_W'($urandom());
		w.end_x       = COORD_W'($urandom());
		w.end_y       = COORD_W'($urandom());
		w.start_owner = OWNER_W'($urandom());
		w.end_owner   = OWNER_W'($urandom());
		w.rect_left   = COORD_W'($urandom());
		w.rect_top    = COORD_W'($urandom());
		w.rect_width  = SIZE_W'($urandom());
		w.rect_height = SIZE_W'($urandom());
		return w;
	endfunction

	function automatic cmd_word_t clear_word();
		cmd_word_t w;
		w     = spare_word();
		w.cmd = CMD_CLEAR;
		return w;
	endfunction

	function automatic cmd_word_t load_word(input logic signed [COORD_W-1:0] l, t,
			input logic [SIZE_W-1:0] wd, ht);
		cmd_word_t w;
		w             = spare_word();
		w.cmd         = CMD_LOAD;
		w.rect_left   = l;
		w.rect_top    = t;
		w.rect_width  = wd;
		w.rect_height = ht;
		return w;
	endfunction

	function automatic cmd_word_t query_word(input logic signed [COORD_W-1:0] sx, sy, ex, ey,
			input logic [OWNER_W-1:0] so, eo);
		cmd_word_t w;
		w             = spare_word();
		w.cmd         = CMD_QUERY;
		w.start_x     = sx;
		w.start_y     = sy;
		w.end_x       = ex;
		w.end_y       = ey;
		w.start_owner = so;
		w.end_owner   = eo;
		return w;
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord(input int span);
		int v;
		if (span >= 32768) return COORD_W'($urandom());
		v = int'($urandom_range(0, 2 * span)) - span;
		return v[COORD_W-1:0];
	endfunction

	function automatic logic [SIZE_W-1:0] rand_size(input int span);
		if ($urandom_range(0, 9) == 0) return '0;
		if (span > 32767) return SIZE_W'($urandom_range(0, 32767));
		return SIZE_W'($urandom_range(0, span));
	endfunction

	function automatic cmd_word_t random_load(input int span);
		return load_word(rand_coord(span), rand_coord(span), rand_size(span), rand_size(span));
	endfunction

	function automatic cmd_word_t random_query(input int span);
		logic [OWNER_W-1:0] so;
		logic [OWNER_W-1:0] eo;
		so = OWNER_W'($urandom_range(0, 63));
		eo = ($urandom_range(0, 4) == 0) ? so : OWNER_W'($urandom_range(0, 63));
		return query_word(rand_coord(span + span / 2), rand_coord(span + span / 2),
			rand_coord(span + span / 2), rand_coord(span + span / 2), so, eo);
	endfunction

	// Push stays high from one word to the next when there is no gap between them.
	task automatic send_word(input cmd_word_t w);
		int gap;
		gap = send_idle_on ? $urandom_range(0, 19) : 0;
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push        <= 1'b1;
		cmd         <= w.cmd;
		start_x     <= w.start_x;
		start_y     <= w.start_y;
		end_x       <= w.end_x;
		end_y       <= w.end_y;
		start_owner <= w.start_owner;
		end_owner   <= w.end_owner;
		rect_left   <= w.rect_left;
		rect_top    <= w.rect_top;
		rect_width  <= w.rect_width;
		rect_height <= w.rect_height;
		do @(posedge clk); while (full);
		record_word(w);
	endtask

	initial begin : result_checker
		int gap;
		int held;
		bit want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (pop_hold_request != 0) begin
				pop <= 1'b0;
				held = 0;
				while (held < pop_hold_request) begin
					@(posedge clk);
					held++;
				end
				pop_hold_request = 0;
			end
			gap = pop_idle_on ? $urandom_range(0, 19) : 0;
			if (gap != 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			results_seen++;
			if (blocked_expected.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing expected",
					results_seen));
			end else begin
				want = blocked_expected.pop_front();
				if (blocked !== want) begin
					report_mismatch($sformatf("result %0d: blocked %b, expected %b",
						results_seen, blocked, want));
				end
			end
		end
	end

	task automatic test_directed();
		send_word(query_word(0, 0, 5, 5, 0, 0));
		send_word(query_word(-32768, 32767, 32767, -32768, 0, 63));
		send_word(query_word(1, 2, 3, 4, 63, 63));
		send_word(load_word(-10, 10, 20, 20));
		send_word(query_word(-20, 0, 20, 0, 1, 2));
		send_word(query_word(-20, 20, 20, 20, 1, 2));
		// Collinear with the top side, meeting the left side only at its end.
		send_word(query_word(-20, 10, 20, 10, 1, 2));
		// The diagonal meets the square's sides only at two corners.
		send_word(query_word(-20, -20, 20, 20, 1, 2));
		send_word(query_word(-20, 0, -10, 0, 1, 2));
		send_word(query_word(-5, -5, 5, 5, 3, 4));
		send_word(spare_word());
		send_word(load_word(100, 100, 0, 0));
		send_word(load_word(50, 50, 0, 40));
		send_word(query_word(40, 30, 60, 30, 7, 8));
		send_word(query_word(99, 99, 101, 101, 7, 8));
		send_word(load_word(-32768, 32767, 32767, 32767));
		send_word(query_word(-32768, -32768, 32767, 32767, 5, 6));
		send_word(query_word(32767, -32768, -32768, 32767, 5, 6));
		send_word(clear_word());
		send_word(query_word(-20, 0, 20, 0, 1, 2));
		// Right and bottom edges lie beyond the 16-bit coordinate range.
		send_word(load_word(32767, -32768, 32767, 32767));
		send_word(query_word(32767, -32768, 0, 32767, 9, 10));
		send_word(query_word(-32768, -1, 32767, -32768, 9, 10));
		send_word(clear_word());
	endtask

	// Fills the table with small far-away rectangles, so that the square offered
	// afterwards must be dropped and the queries near the origin stay clear.
	task automatic test_table_full();
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by;
		send_word(clear_word());
		repeat (TABLE_DEPTH) begin
			bx = COORD_W'(20000 + $urandom_range(0, 1000));
			by = COORD_W'(20000 + $urandom_range(0, 1000));
			send_word(load_word(bx, by, rand_size(40), rand_size(40)));
		end
		send_word(load_word(-10, 10, 20, 20));
		send_word(random_load(12));
		send_word(query_word(-20, 0, 20, 0, 1, 2));
		repeat (4) send_word(random_query(12));
		repeat (6) begin
			bx = COORD_W'(19990 + $urandom_range(0, 1050));
			by = COORD_W'(19990 + $urandom_range(0, 1050));
			send_word(query_word(bx, by, COORD_W'(bx + $urandom_range(0, 60) - 30),
				COORD_W'(by + $urandom_range(0, 60) - 30), 11, 12));
		end
		send_word(clear_word());
		send_word(load_word(-10, 10, 20, 20));
		send_word(query_word(-20, 0, 20, 0, 1, 2));
	endtask

	// The receiver stops for a long while so that both queues fill and full rises.
	task automatic test_backpressure();
		send_word(clear_word());
		repeat (4) send_word(random_load(12));
		send_idle_on     = 1'b0;
		pop_hold_request = 600;
		repeat (16) send_word(random_query(12));
		send_idle_on = 1'b1;
	endtask

	// Scenes of clear, a few loads and several queries, mostly on a small grid
	// where touching, collinear and corner cases come up often.
	task automatic test_random_scenes(input int target);
		int sent;
		int pick;
		int span;
		int nrect;
		int nq;
		sent = 0;
		while (sent < target) begin
			pick         = $urandom_range(0, 99);
			span         = (pick < 65) ? 12 : ((pick < 90) ? 2000 : 32768);
			send_idle_on = ($urandom_range(0, 99) >= 15);
			pop_idle_on  = ($urandom_range(0, 99) >= 15);
			if ($urandom_range(0, 9) != 0) begin
				send_word(clear_word());
				sent++;
			end
			nrect = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
			repeat (nrect) begin
				send_word(random_load(span));
				sent++;
			end
			nq = $urandom_range(0, 8);
			repeat (nq) begin
				if ($urandom_range(0, 19) == 0) send_word(spare_word());
				send_word(random_query(span));
				sent++;
			end
		end
		send_idle_on = 1'b1;
		pop_idle_on  = 1'b1;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table_full();
		test_backpressure();
		test_random_scenes(630);
		push <= 1'b0;
		while (blocked_expected.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("segment_rectangle_visibility_check_unit regression: pass");
		end else begin
			$display("segment_rectangle_visibility_check_unit regression: fail");
		end
		$finish;
	end

endmodule
